// File: src/mime_header_param_tokenizer_macros.svh
// ----------------------------------------------------------------------------
// MIME header parameter tokenizer: assertion macros
// Shared concurrent assertion forms, clocked on clk and idle during reset.
// ----------------------------------------------------------------------------
`ifndef MIME_HEADER_PARAM_TOKENIZER_MACROS_SVH
`define MIME_HEADER_PARAM_TOKENIZER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MHPT_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define MHPT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: src/mhpt_pkg.sv
// ----------------------------------------------------------------------------
// MIME header parameter tokenizer: package
// Shared types for the character classifier, the parser step and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package mhpt_pkg;

  // Parser states, one-hot.
  typedef enum logic [7:0] {
    ST_BEGIN      = 8'b0000_0001,
    ST_VALUE      = 8'b0000_0010,
    ST_ATTR_BEGIN = 8'b0000_0100,
    ST_ATTR_NAME  = 8'b0000_1000,
    ST_ATTR_VALUE = 8'b0001_0000,
    ST_QVALUE     = 8'b0010_0000,
    ST_TVALUE     = 8'b0100_0000,
    ST_VALUE_END  = 8'b1000_0000
  } state_t;

  // Role of a byte in the header value.
  typedef enum logic [1:0] {
    ROLE_SKIP = 2'd0,
    ROLE_MAIN = 2'd1,
    ROLE_NAME = 2'd2,
    ROLE_PVAL = 2'd3
  } role_t;

  // Character class flags of one byte.
  typedef struct packed {
    logic space;
    logic alnum;
    logic attr;
    logic value;
    logic qtext;
    logic semi;
    logic equal;
    logic quote;
  } class_t;

  // Result of one parser step.
  typedef struct packed {
    state_t state;
    logic   err;
    logic   pend;
    role_t  role;
    logic   commit;
    logic   err_flag;
  } step_t;

endpackage

`default_nettype wire

// File: src/mhpt_char_class.sv
// ----------------------------------------------------------------------------
// MIME header parameter tokenizer: character classifier
// Sorts one byte into the lexical classes used by the parser.
// ----------------------------------------------------------------------------
`default_nettype none

module mhpt_char_class (
  input  wire logic [7:0]      char_i,
  output mhpt_pkg::class_t     cls_o
);

  logic punct_attr;
  logic punct_qtext;

  always_comb begin
    cls_o       = '0;
    punct_attr  = 1'b0;
    punct_qtext = 1'b0;

    cls_o.space = (char_i == 8'h20) || (char_i inside {[8'h09:8'h0D]});
    cls_o.alnum = (char_i inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]});

    // Token punctuation: ! # $ % & * + - . ^ _ ` | ~
    punct_attr = (char_i inside {8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h2A, 8'h2B,
                                 8'h2D, 8'h2E, 8'h5E, 8'h5F, 8'h60, 8'h7C, 8'h7E});

    // Quoted text punctuation, HT and space; no double quote, no backslash.
    punct_qtext = (char_i inside {8'h09, 8'h20, 8'h21, [8'h23:8'h2F], [8'h3A:8'h40],
                                  8'h5B, [8'h5D:8'h60], [8'h7B:8'h7E]});

    cls_o.attr  = cls_o.alnum || punct_attr;
    cls_o.value = cls_o.attr || (char_i == 8'h2F);
    cls_o.qtext = cls_o.alnum || punct_qtext;
    cls_o.semi  = (char_i == 8'h3B);
    cls_o.equal = (char_i == 8'h3D);
    cls_o.quote = (char_i == 8'h22);
  end

endmodule

`default_nettype wire

// File: src/mhpt_step.sv
// ----------------------------------------------------------------------------
// MIME header parameter tokenizer: parser step
// Next-state, role, commit and error logic for one byte.
// ----------------------------------------------------------------------------
`default_nettype none

module mhpt_step (
  input  wire mhpt_pkg::state_t state_i,
  input  wire logic             err_i,
  input  wire logic             pend_i,
  input  wire mhpt_pkg::class_t cls_i,
  input  wire logic             last_i,
  output mhpt_pkg::step_t       step_o
);

  logic bad;

  always_comb begin
    step_o       = '0;
    step_o.state = state_i;
    step_o.err   = err_i;
    step_o.pend  = pend_i;
    step_o.role  = mhpt_pkg::ROLE_SKIP;
    bad          = 1'b0;

    if (!err_i) begin
      case (state_i)
        mhpt_pkg::ST_VALUE: begin
          if (cls_i.value) begin
            step_o.role = mhpt_pkg::ROLE_MAIN;
          end else if (cls_i.semi) begin
            step_o.state = mhpt_pkg::ST_ATTR_BEGIN;
          end else begin
            bad = 1'b1;
          end
        end
        mhpt_pkg::ST_ATTR_BEGIN: begin
          if (cls_i.space) begin
            step_o.state = state_i;
          end else if (cls_i.attr) begin
            step_o.state = mhpt_pkg::ST_ATTR_NAME;
            step_o.role  = mhpt_pkg::ROLE_NAME;
          end else if (cls_i.equal) begin
            step_o.state = mhpt_pkg::ST_ATTR_VALUE;
          end else begin
            bad = 1'b1;
          end
        end
        mhpt_pkg::ST_ATTR_NAME: begin
          // Stray bytes inside a name are dropped without error.
          if (cls_i.attr) begin
            step_o.role = mhpt_pkg::ROLE_NAME;
          end else if (cls_i.equal) begin
            step_o.state = mhpt_pkg::ST_ATTR_VALUE;
          end
        end
        mhpt_pkg::ST_ATTR_VALUE: begin
          if (cls_i.quote) begin
            step_o.state = mhpt_pkg::ST_QVALUE;
            step_o.pend  = 1'b1;
          end else if (cls_i.attr) begin
            step_o.state = mhpt_pkg::ST_TVALUE;
            step_o.pend  = 1'b1;
            step_o.role  = mhpt_pkg::ROLE_PVAL;
          end else begin
            bad = 1'b1;
          end
        end
        mhpt_pkg::ST_QVALUE: begin
          if (cls_i.qtext) begin
            step_o.role = mhpt_pkg::ROLE_PVAL;
          end else if (cls_i.quote) begin
            step_o.state  = mhpt_pkg::ST_VALUE_END;
            step_o.commit = pend_i;
            step_o.pend   = 1'b0;
          end else begin
            bad = 1'b1;
          end
        end
        mhpt_pkg::ST_TVALUE: begin
          if (cls_i.attr) begin
            step_o.role = mhpt_pkg::ROLE_PVAL;
          end else if (cls_i.space) begin
            step_o.state  = mhpt_pkg::ST_VALUE_END;
            step_o.commit = pend_i;
            step_o.pend   = 1'b0;
          end else if (cls_i.semi) begin
            step_o.state  = mhpt_pkg::ST_ATTR_BEGIN;
            step_o.commit = pend_i;
            step_o.pend   = 1'b0;
          end else begin
            bad = 1'b1;
          end
        end
        mhpt_pkg::ST_VALUE_END: begin
          if (cls_i.space) begin
            step_o.state = state_i;
          end else if (cls_i.semi) begin
            step_o.state = mhpt_pkg::ST_ATTR_BEGIN;
          end else begin
            bad = 1'b1;
          end
        end
        default: begin
          // Begin state, and any code that is not a valid state.
          if (cls_i.space) begin
            step_o.state = state_i;
          end else if (cls_i.alnum) begin
            step_o.state = mhpt_pkg::ST_VALUE;
            step_o.role  = mhpt_pkg::ROLE_MAIN;
          end else begin
            bad = 1'b1;
          end
        end
      endcase
    end

    if (bad) begin
      step_o.err    = 1'b1;
      step_o.role   = mhpt_pkg::ROLE_SKIP;
      step_o.commit = 1'b0;
    end

    // A value still open on the final byte is committed there.
    if (!step_o.err && last_i && step_o.pend) begin
      step_o.commit = 1'b1;
      step_o.pend   = 1'b0;
    end

    step_o.err_flag = step_o.err;

    if (last_i) begin
      step_o.state = mhpt_pkg::ST_BEGIN;
      step_o.err   = 1'b0;
      step_o.pend  = 1'b0;
    end
  end

endmodule

`default_nettype wire

// File: src/mime_header_param_tokenizer.sv
// ----------------------------------------------------------------------------
// MIME header parameter tokenizer
// Byte-at-a-time tokenizer for header values of the form
// value; name=value; name="quoted text".
// ----------------------------------------------------------------------------
// The block takes one byte of a header value per request, with a flag on the
// final byte, and returns the same byte tagged with its role: skipped, main
// value, parameter name or parameter value. A commit strobe marks the byte on
// which a name/value pair is complete (closing quote, space or ';' after a
// token value, or the final byte while a value is still open), and a sticky
// error flag goes high on the first illegal byte and stays high until the
// final byte of that header; the parser is then frozen and every byte reports
// the skip role. The final byte returns the parser to its initial state, so
// the next header starts clean. Throughput is one byte per clock cycle, held
// indefinitely while the output is not stalled: a byte is first captured in
// an input register and is then classified and run through the parser state
// on its way into the result register, which presents it on the result
// channel. The parser state is updated only in that second stage, so
// back-to-back bytes see each other's state without any bubble. Both
// registers advance whenever the stage ahead of them is empty or moving, so
// input stall rises only when both stages are full and the output is stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module mime_header_param_tokenizer (
  input  wire logic       clk,
  input  wire logic       rst_n,
  // Input channel
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_char_in,
  input  wire logic       in_is_last,
  // Result channel
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_char_out,
  output logic [1:0]      out_role,
  output logic            out_commit_pair,
  output logic            out_error_flag,
  output logic            out_last_out
);

  `include "mime_header_param_tokenizer_macros.svh"

  // Input register stage.
  logic       s1_valid_r;
  logic       s1_valid_nxt;
  logic [7:0] s1_char_r;
  logic       s1_last_r;

  // Parser state, updated when a byte moves from the input register into the
  // result register.
  mhpt_pkg::state_t state_r;
  mhpt_pkg::state_t state_nxt;
  logic             err_r;
  logic             err_nxt;
  logic             pend_r;
  logic             pend_nxt;

  // Result register stage.
  logic             out_valid_r;
  logic             out_valid_nxt;
  logic [7:0]       char_out_r;
  mhpt_pkg::role_t  role_r;
  logic             commit_r;
  logic             error_r;
  logic             last_r;

  logic             adv_out;
  logic             adv_in;
  logic             take;
  mhpt_pkg::class_t cls;
  mhpt_pkg::step_t  step;

  // The result register can load when it is empty or being drained; the
  // input register can load when it is empty or moving forward.
  assign adv_out  = !out_valid_r || !out_stall;
  assign adv_in   = !s1_valid_r || adv_out;
  assign in_stall = !adv_in;
  assign take     = s1_valid_r && adv_out;

  mhpt_char_class u_class (
    .char_i (s1_char_r),
    .cls_o  (cls)
  );

  mhpt_step u_step (
    .state_i (state_r),
    .err_i   (err_r),
    .pend_i  (pend_r),
    .cls_i   (cls),
    .last_i  (s1_last_r),
    .step_o  (step)
  );

  always_comb begin
    s1_valid_nxt  = adv_in ? in_valid : s1_valid_r;
    out_valid_nxt = adv_out ? s1_valid_r : out_valid_r;
    state_nxt     = take ? step.state : state_r;
    err_nxt       = take ? step.err : err_r;
    pend_nxt      = take ? step.pend : pend_r;
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= mhpt_pkg::ST_BEGIN;
      err_r       <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      state_r     <= state_nxt;
      err_r       <= err_nxt;
      pend_r      <= pend_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (adv_in) begin
      s1_char_r <= in_char_in;
      s1_last_r <= in_is_last;
    end
    if (take) begin
      char_out_r <= s1_char_r;
      role_r     <= step.role;
      commit_r   <= step.commit;
      error_r    <= step.err_flag;
      last_r     <= s1_last_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_char_out    = char_out_r;
  assign out_role        = role_r;
  assign out_commit_pair = commit_r;
  assign out_error_flag  = error_r;
  assign out_last_out    = last_r;

  // A result that reports an error carries no role and no commit.
  `MHPT_ASSERT_SAME(a_err_quiet, out_valid_r && error_r,
                    role_r == mhpt_pkg::ROLE_SKIP && !commit_r)

  // A pair can only be pending while a parameter value is open.
  `MHPT_ASSERT_SAME(a_pend_in_value, pend_r,
                    state_r == mhpt_pkg::ST_QVALUE || state_r == mhpt_pkg::ST_TVALUE)

  // The final byte of a header leaves the parser clean for the next one.
  `MHPT_ASSERT_NEXT(a_last_clears, take && s1_last_r,
                    state_r == mhpt_pkg::ST_BEGIN && !err_r && !pend_r)

endmodule

`default_nettype wire
